>>> rtl/smeu_pkg.sv
// smeu_pkg: sizes, opcodes and fault codes of the stack machine execute unit
// no dependencies; imported by the execute unit top level

package smeu_pkg;

  localparam int EVAL_DEPTH   = 64;
  localparam int FRAME_DEPTH  = 1024;
  localparam int GLOBAL_DEPTH = 1024;
  localparam int CODE_DEPTH   = 4096;
  localparam int GLOBAL_SPLIT = 1000;

  localparam int EV_AW   = $clog2(EVAL_DEPTH);
  localparam int CNT_W   = $clog2(EVAL_DEPTH + 1);
  localparam int FR_AW   = $clog2(FRAME_DEPTH);
  localparam int GL_AW   = $clog2(GLOBAL_DEPTH);
  localparam int HALF_AW = (FR_AW > GL_AW) ? FR_AW : GL_AW;
  localparam int DM_AW   = HALF_AW + 1;
  localparam int DM_DEPTH = 2 ** DM_AW;
  localparam int IP_W    = $clog2(CODE_DEPTH + 1);
  localparam int NIP_W   = 12;
  localparam int PLEN_W  = 13;
  localparam int PADDR_W = 3;

  localparam logic REG_PROGRAM_LENGTH = 1'b0;

  typedef enum logic [4:0] {
    OP_LOAD   = 5'd0,
    OP_LOADI  = 5'd1,
    OP_STO    = 5'd2,
    OP_ADD    = 5'd3,
    OP_SUB    = 5'd4,
    OP_MULT   = 5'd5,
    OP_DIV    = 5'd6,
    OP_BR     = 5'd7,
    OP_BRF    = 5'd8,
    OP_EQ     = 5'd9,
    OP_NOTEQ  = 5'd10,
    OP_GT     = 5'd11,
    OP_LES    = 5'd12,
    OP_GE     = 5'd13,
    OP_LE     = 5'd14,
    OP_AND    = 5'd15,
    OP_OR     = 5'd16,
    OP_NOT    = 5'd17,
    OP_IN     = 5'd18,
    OP_OUT    = 5'd19,
    OP_CAL    = 5'd20,
    OP_ENTER  = 5'd21,
    OP_RETURN = 5'd22
  } opcode_t;

  typedef enum logic [2:0] {
    F_OK     = 3'd0,
    F_UNDER  = 3'd1,
    F_OVER   = 3'd2,
    F_DIV0   = 3'd3,
    F_ADDR   = 3'd4,
    F_TARGET = 3'd5
  } fault_t;

  typedef struct packed {
    logic              go;
    logic [IP_W-1:0]   nip;
    logic              ov;
    logic [31:0]       oval;
    logic [2:0]        fault;
  } fin_t;

endpackage

>>> rtl/smeu_ram.sv
// smeu_ram: generic single-write, single-read synchronous ram
// registered read data; no dependencies

module smeu_ram #(
  parameter int W = 32,
  parameter int D = 64
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [$clog2(D)-1:0] waddr,
  input  logic [W-1:0]         wdata,
  input  logic [$clog2(D)-1:0] raddr,
  output logic [W-1:0]         rdata
);

  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/stack_machine_execute_unit.sv
// stack_machine_execute_unit: executes one stack-machine instruction per item
// depends on smeu_pkg and smeu_ram (operand stack ram, frame/global data ram)

// Usage: the host fetches the instruction at out_next_ip and presents its
// opcode, operand and IN value on the in_ channel (valid/stall). Each item
// yields exactly one result on the out_ channel: the next instruction
// pointer, the OUT value if any, the halted flag and a fault code.
// program_length is written over the APB port at byte address 0 while idle.
// Sequence: a halted item finishes in the idle state, others in S_EXEC; CAL
// and RETURN add CAL2/RET2 (two accesses to the data ram), DIV adds S_DIV (the
// restoring divider retires one quotient bit per cycle). The top of stack
// lives in a register, the rest in the stack ram, so a binary op needs one
// stack read. The result sits in an output register; the next item is taken
// while it waits. If the receiver stalls and the output register is still
// full when a new result is ready, the unit holds it and stalls its input.
// Reset: after rst_n the data ram is swept to zero, one word per cycle,
// with in_stall high; configuration writes are taken meanwhile.

module stack_machine_execute_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [4:0]                    in_kind,
  input  logic signed [31:0]            in_operand,
  input  logic signed [31:0]            in_in_value,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [smeu_pkg::NIP_W-1:0]    out_next_ip,
  output logic                          out_out_valid,
  output logic signed [31:0]            out_out_value,
  output logic                          out_halted,
  output logic [2:0]                    out_fault,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [smeu_pkg::PADDR_W-1:0]  paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);
  import smeu_pkg::*;

  typedef enum logic [2:0] {
    S_CLR, S_IDLE, S_EXEC, S_CAL2, S_RET2, S_DIV, S_RESP
  } state_t;

  state_t              state_r, state_nxt;
  logic [DM_AW-1:0]    clr_r, clr_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [31:0]         tos_r, tos_nxt;
  logic [FR_AW-1:0]    base_r, base_nxt;
  logic [FR_AW-1:0]    top_r, top_nxt;
  logic [IP_W-1:0]     ip_r, ip_nxt;
  logic [PLEN_W-1:0]   plen_r, plen_nxt;
  logic [4:0]          k_r, k_nxt;
  logic signed [31:0]  op_r, op_nxt;
  logic [31:0]         inv_r, inv_nxt;
  logic [DM_AW-1:0]    addr_r, addr_nxt;
  logic                aok_r, aok_nxt;
  logic [FR_AW-1:0]    rb_r, rb_nxt;
  logic [4:0]          dcnt_r, dcnt_nxt;
  logic [31:0]         drem_r, drem_nxt;
  logic [31:0]         dq_r, dq_nxt;
  logic [31:0]         dd_r, dd_nxt;
  logic                dneg_r, dneg_nxt;
  logic                ovalid_r, ovalid_nxt;
  fin_t                ores_r, ores_nxt;
  fin_t                pend_r, pend_nxt;
  fin_t                fin;

  logic                s_we;
  logic [EV_AW-1:0]    s_waddr, s_raddr;
  logic [31:0]         s_wdata, s_rdata;
  logic                d_we;
  logic [DM_AW-1:0]    d_waddr, d_raddr;
  logic [31:0]         d_wdata, d_rdata;

  logic                out_free;
  logic [IP_W-1:0]     ip1;
  logic signed [33:0]  li, gi, ent;
  logic                isg, acc_ok;
  logic [DM_AW-1:0]    acc_addr;
  logic signed [31:0]  a, b;
  logic [31:0]         r, abs_a, abs_b, q_step, quo;
  logic [32:0]         dtrial;
  logic                tgt_ok;

  smeu_ram #(.W(32), .D(EVAL_DEPTH)) u_stack (
    .clk(clk), .we(s_we), .waddr(s_waddr), .wdata(s_wdata),
    .raddr(s_raddr), .rdata(s_rdata)
  );

  smeu_ram #(.W(32), .D(DM_DEPTH)) u_data (
    .clk(clk), .we(d_we), .waddr(d_waddr), .wdata(d_wdata),
    .raddr(d_raddr), .rdata(d_rdata)
  );

  assign pready   = 1'b1;
  assign prdata   = (paddr[2] == REG_PROGRAM_LENGTH) ? 32'(plen_r) : 32'd0;
  assign in_stall = (state_r != S_IDLE);
  assign out_free = !ovalid_r || !out_stall;
  assign ip1      = ip_r + 1'b1;

  // local/global address of the incoming operand
  assign li  = 34'(in_operand) + 34'(signed'({1'b0, base_r}));
  assign gi  = 34'(in_operand) - 34'(GLOBAL_SPLIT);
  assign isg = in_operand > GLOBAL_SPLIT;
  assign acc_ok = isg ? (gi < GLOBAL_DEPTH) : (li >= 0 && li < FRAME_DEPTH);
  assign acc_addr = isg ? {1'b1, gi[HALF_AW-1:0]} : {1'b0, li[HALF_AW-1:0]};

  assign a = signed'(s_rdata);
  assign b = signed'(tos_r);
  assign abs_a = a[31] ? (32'd0 - s_rdata) : s_rdata;
  assign abs_b = b[31] ? (32'd0 - tos_r) : tos_r;
  assign ent = 34'(op_r) + 34'(signed'({1'b0, top_r}));
  assign tgt_ok = (op_r >= 0) && (op_r < CODE_DEPTH);

  always_comb begin
    case (k_r)
      OP_ADD:   r = s_rdata + tos_r;
      OP_SUB:   r = s_rdata - tos_r;
      OP_MULT:  r = 32'(a * b);
      OP_EQ:    r = 32'(a == b);
      OP_NOTEQ: r = 32'(a != b);
      OP_GT:    r = 32'(a > b);
      OP_LES:   r = 32'(a < b);
      OP_GE:    r = 32'(a >= b);
      OP_LE:    r = 32'(a <= b);
      OP_AND:   r = 32'((a != 0) && (b != 0));
      OP_OR:    r = 32'((a != 0) || (b != 0));
      default:  r = 32'd0;
    endcase
  end

  // one restoring divide step
  assign dtrial = {drem_r, dq_r[31]};
  assign q_step = {dq_r[30:0], (dtrial >= {1'b0, dd_r})};
  assign quo    = dneg_r ? (32'd0 - q_step) : q_step;

  always_comb begin
    state_nxt = state_r;
    clr_nxt   = clr_r;
    cnt_nxt   = cnt_r;
    tos_nxt   = tos_r;
    base_nxt  = base_r;
    top_nxt   = top_r;
    plen_nxt  = plen_r;
    k_nxt     = k_r;
    op_nxt    = op_r;
    inv_nxt   = inv_r;
    addr_nxt  = addr_r;
    aok_nxt   = aok_r;
    rb_nxt    = rb_r;
    dcnt_nxt  = dcnt_r;
    drem_nxt  = drem_r;
    dq_nxt    = dq_r;
    dd_nxt    = dd_r;
    dneg_nxt  = dneg_r;
    ovalid_nxt = ovalid_r;
    ores_nxt  = ores_r;
    pend_nxt  = pend_r;
    s_we      = 1'b0;
    s_waddr   = EV_AW'(cnt_r - 1'b1);
    s_wdata   = tos_r;
    s_raddr   = EV_AW'(cnt_r - 2'd2);
    d_we      = 1'b0;
    d_waddr   = addr_r;
    d_wdata   = tos_r;
    d_raddr   = acc_addr;
    fin.go    = 1'b0;
    fin.nip   = ip1;
    fin.ov    = 1'b0;
    fin.oval  = 32'd0;
    fin.fault = F_OK;

    if (psel && penable && pwrite && paddr[2] == REG_PROGRAM_LENGTH) begin
      plen_nxt = pwdata[PLEN_W-1:0];
    end
    if (ovalid_r && !out_stall) begin
      ovalid_nxt = 1'b0;
    end

    case (state_r)
      S_CLR: begin
        d_we    = 1'b1;
        d_waddr = clr_r;
        d_wdata = 32'd0;
        clr_nxt = clr_r + 1'b1;
        if (clr_r == DM_AW'(DM_DEPTH - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_kind == OP_RETURN) begin
          d_raddr = {1'b0, HALF_AW'(base_r)};
        end
        if (in_valid) begin
          k_nxt    = in_kind;
          op_nxt   = in_operand;
          inv_nxt  = in_in_value;
          addr_nxt = acc_addr;
          aok_nxt  = acc_ok;
          if (ip_r >= IP_W'(plen_r)) begin
            fin.go  = 1'b1;
            fin.nip = ip_r;
          end else begin
            state_nxt = S_EXEC;
          end
        end
      end
      S_EXEC: begin
        fin.go = 1'b1;
        d_raddr = {1'b0, HALF_AW'(base_r + 1'b1)};
        case (k_r)
          OP_LOAD, OP_LOADI, OP_IN: begin
            if (cnt_r >= CNT_W'(EVAL_DEPTH)) begin
              fin.fault = F_OVER;
            end else if (k_r == OP_LOAD && !aok_r) begin
              fin.fault = F_ADDR;
            end else begin
              s_we    = (cnt_r != '0);
              cnt_nxt = cnt_r + 1'b1;
              tos_nxt = (k_r == OP_LOAD) ? d_rdata :
                        (k_r == OP_LOADI) ? op_r : inv_r;
            end
          end
          OP_STO: begin
            if (cnt_r < 1) begin
              fin.fault = F_UNDER;
            end else if (!aok_r) begin
              fin.fault = F_ADDR;
            end else begin
              d_we    = 1'b1;
              tos_nxt = s_rdata;
              cnt_nxt = cnt_r - 1'b1;
            end
          end
          OP_ADD, OP_SUB, OP_MULT, OP_DIV, OP_EQ, OP_NOTEQ, OP_GT, OP_LES,
          OP_GE, OP_LE, OP_AND, OP_OR: begin
            if (cnt_r < 2) begin
              fin.fault = F_UNDER;
            end else if (k_r == OP_DIV) begin
              if (tos_r == 32'd0) begin
                fin.fault = F_DIV0;
              end else begin
                fin.go    = 1'b0;
                dq_nxt    = abs_a;
                dd_nxt    = abs_b;
                drem_nxt  = 32'd0;
                dcnt_nxt  = 5'd0;
                dneg_nxt  = a[31] ^ b[31];
                state_nxt = S_DIV;
              end
            end else begin
              tos_nxt = r;
              cnt_nxt = cnt_r - 1'b1;
            end
          end
          OP_BR: begin
            if (!tgt_ok) begin
              fin.fault = F_TARGET;
            end else begin
              fin.nip = IP_W'(op_r);
            end
          end
          OP_BRF: begin
            if (cnt_r < 1) begin
              fin.fault = F_UNDER;
            end else if (tos_r == 32'd0 && !tgt_ok) begin
              fin.fault = F_TARGET;
            end else begin
              if (tos_r == 32'd0) begin
                fin.nip = IP_W'(op_r);
              end
              tos_nxt = s_rdata;
              cnt_nxt = cnt_r - 1'b1;
            end
          end
          OP_NOT: begin
            if (cnt_r < 1) begin
              fin.fault = F_UNDER;
            end else begin
              tos_nxt = 32'(tos_r == 32'd0);
            end
          end
          OP_OUT: begin
            if (cnt_r < 1) begin
              fin.fault = F_UNDER;
            end else begin
              fin.ov   = 1'b1;
              fin.oval = tos_r;
              tos_nxt  = s_rdata;
              cnt_nxt  = cnt_r - 1'b1;
            end
          end
          OP_CAL: begin
            if (top_r == FR_AW'(FRAME_DEPTH - 1)) begin
              fin.fault = F_ADDR;
            end else if (!tgt_ok) begin
              fin.fault = F_TARGET;
            end else begin
              // save the caller's base now, the return ip next cycle
              fin.go    = 1'b0;
              d_we      = 1'b1;
              d_waddr   = {1'b0, HALF_AW'(top_r)};
              d_wdata   = 32'(base_r);
              state_nxt = S_CAL2;
            end
          end
          OP_ENTER: begin
            if (ent < 0 || ent >= FRAME_DEPTH) begin
              fin.fault = F_ADDR;
            end else begin
              top_nxt = ent[FR_AW-1:0];
            end
          end
          OP_RETURN: begin
            if (base_r == FR_AW'(FRAME_DEPTH - 1) || d_rdata >= 32'(FRAME_DEPTH)) begin
              fin.fault = F_ADDR;
            end else begin
              fin.go    = 1'b0;
              rb_nxt    = d_rdata[FR_AW-1:0];
              state_nxt = S_RET2;
            end
          end
          default: begin
          end
        endcase
      end
      S_CAL2: begin
        fin.go   = 1'b1;
        d_we     = 1'b1;
        d_waddr  = {1'b0, HALF_AW'(top_r + 1'b1)};
        d_wdata  = 32'(ip1);
        base_nxt = top_r;
        fin.nip  = IP_W'(op_r);
      end
      S_RET2: begin
        fin.go = 1'b1;
        if (d_rdata >= 32'(CODE_DEPTH)) begin
          fin.fault = F_TARGET;
        end else begin
          top_nxt  = base_r;
          base_nxt = rb_r;
          fin.nip  = d_rdata[IP_W-1:0];
        end
      end
      S_DIV: begin
        dq_nxt   = q_step;
        drem_nxt = (dtrial >= {1'b0, dd_r}) ? 32'(dtrial - {1'b0, dd_r}) : dtrial[31:0];
        dcnt_nxt = dcnt_r + 1'b1;
        if (dcnt_r == 5'd31) begin
          fin.go  = 1'b1;
          tos_nxt = quo;
          cnt_nxt = cnt_r - 1'b1;
        end
      end
      S_RESP: begin
        if (out_free) begin
          ores_nxt   = pend_r;
          ovalid_nxt = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (fin.fault != F_OK) begin
      fin.nip = ip_r;
    end
    ip_nxt = fin.go ? fin.nip : ip_r;
    if (fin.go) begin
      if (out_free) begin
        ores_nxt   = fin;
        ovalid_nxt = 1'b1;
        state_nxt  = S_IDLE;
      end else begin
        pend_nxt  = fin;
        state_nxt = S_RESP;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_CLR;
      clr_r    <= '0;
      cnt_r    <= '0;
      base_r   <= '0;
      top_r    <= '0;
      ip_r     <= '0;
      plen_r   <= '0;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      clr_r    <= clr_nxt;
      cnt_r    <= cnt_nxt;
      base_r   <= base_nxt;
      top_r    <= top_nxt;
      ip_r     <= ip_nxt;
      plen_r   <= plen_nxt;
      ovalid_r <= ovalid_nxt;
    end
    tos_r  <= tos_nxt;
    k_r    <= k_nxt;
    op_r   <= op_nxt;
    inv_r  <= inv_nxt;
    addr_r <= addr_nxt;
    aok_r  <= aok_nxt;
    rb_r   <= rb_nxt;
    dcnt_r <= dcnt_nxt;
    drem_r <= drem_nxt;
    dq_r   <= dq_nxt;
    dd_r   <= dd_nxt;
    dneg_r <= dneg_nxt;
    ores_r <= ores_nxt;
    pend_r <= pend_nxt;
  end

  assign out_valid     = ovalid_r;
  assign out_next_ip   = ores_r.nip[NIP_W-1:0];
  assign out_out_valid = ores_r.ov;
  assign out_out_value = signed'(ores_r.oval);
  assign out_halted    = (ores_r.nip >= IP_W'(plen_r));
  assign out_fault     = ores_r.fault;

`ifndef SYNTHESIS
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(EVAL_DEPTH))
    else $error("operand stack count beyond depth");
  a_pend_full: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_RESP |-> ovalid_r)
    else $error("result held back while output register empty");
  a_fault_ip: assert property (@(posedge clk) disable iff (!rst_n)
    (fin.go && fin.fault != F_OK) |=> ip_r == $past(ip_r))
    else $error("faulting instruction moved the instruction pointer");
  a_clr_stall: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_CLR |=> !ovalid_r)
    else $error("result produced during memory clear");
`endif

endmodule

>>> tb/tb_stack_machine_execute_unit.sv
// testbench for stack_machine_execute_unit: directed and random instruction streams
// depends on smeu_pkg and the execute unit rtl; self-checking through a scoreboard class
`timescale 1ns / 1ps

module tb_stack_machine_execute_unit;
  import smeu_pkg::*;

  typedef struct packed {
    logic [11:0] next_ip;
    logic        out_valid;
    logic [31:0] out_value;
    logic        halted;
    logic [2:0]  fault;
  } exec_result_t;

  class exec_scoreboard;
    logic [31:0] opstack [EVAL_DEPTH];
    int unsigned depth;
    logic [31:0] frame_words [FRAME_DEPTH];
    logic [31:0] global_words [GLOBAL_DEPTH];
    int unsigned base_ptr, top_ptr, ip, plen;
    exec_result_t pending[$];
    int mismatches;
    int checked;
    int outs_seen;

    function void clear_state();
      depth = 0; base_ptr = 0; top_ptr = 0; ip = 0; plen = 0;
      foreach (frame_words[i]) frame_words[i] = '0;
      foreach (global_words[i]) global_words[i] = '0;
      foreach (opstack[i]) opstack[i] = '0;
    endfunction

    // returns -1 when the address is outside both memories
    function int locate(longint a, output bit is_global);
      longint l;
      is_global = 0;
      if (a > GLOBAL_SPLIT) begin
        is_global = 1;
        if (a - GLOBAL_SPLIT < GLOBAL_DEPTH) return int'(a - GLOBAL_SPLIT);
        return -1;
      end
      l = a + longint'(base_ptr);
      if (l >= 0 && l < FRAME_DEPTH) return int'(l);
      return -1;
    endfunction

    function void note_instr(logic [4:0] kind, logic signed [31:0] opnd, logic [31:0] inv);
      exec_result_t r;
      int unsigned nip;
      fault_t f;
      longint a, b, res, t, o;
      int idx;
      bit g;
      logic [31:0] v, rb, ri;
      r = '0;
      o = longint'(opnd);
      f = F_OK;
      nip = ip + 1;
      if (ip >= plen) begin
        r.next_ip = ip[11:0]; r.halted = 1;
        pending = {pending, r};
        return;
      end
      case (kind)
        OP_LOAD, OP_LOADI, OP_IN: begin
          if (depth >= EVAL_DEPTH) f = F_OVER;
          else begin
            v = inv;
            if (kind == OP_LOADI) v = opnd;
            if (kind == OP_LOAD) begin
              idx = locate(o, g);
              if (idx < 0) f = F_ADDR;
              else v = g ? global_words[idx] : frame_words[idx];
            end
            if (f == F_OK) begin opstack[depth] = v; depth++; end
          end
        end
        OP_STO: begin
          if (depth < 1) f = F_UNDER;
          else begin
            idx = locate(o, g);
            if (idx < 0) f = F_ADDR;
            else begin
              depth--;
              if (g) global_words[idx] = opstack[depth];
              else frame_words[idx] = opstack[depth];
            end
          end
        end
        OP_ADD, OP_SUB, OP_MULT, OP_DIV, OP_EQ, OP_NOTEQ, OP_GT, OP_LES, OP_GE,
        OP_LE, OP_AND, OP_OR: begin
          if (depth < 2) f = F_UNDER;
          else begin
            a = longint'($signed(opstack[depth-2]));
            b = longint'($signed(opstack[depth-1]));
            res = 0;
            case (kind)
              OP_ADD:   res = a + b;
              OP_SUB:   res = a - b;
              OP_MULT:  res = a * b;
              OP_DIV:   if (b == 0) f = F_DIV0; else res = a / b;
              OP_EQ:    res = (a == b);
              OP_NOTEQ: res = (a != b);
              OP_GT:    res = (a > b);
              OP_LES:   res = (a < b);
              OP_GE:    res = (a >= b);
              OP_LE:    res = (a <= b);
              OP_AND:   res = (a != 0 && b != 0);
              default:  res = (a != 0 || b != 0);
            endcase
            if (f == F_OK) begin depth--; opstack[depth-1] = res[31:0]; end
          end
        end
        OP_BR: if (o < 0 || o >= CODE_DEPTH) f = F_TARGET; else nip = 32'(o);
        OP_BRF: begin
          if (depth < 1) f = F_UNDER;
          else begin
            if (opstack[depth-1] == 0) begin
              if (o < 0 || o >= CODE_DEPTH) f = F_TARGET; else nip = 32'(o);
            end
            if (f == F_OK) depth--;
          end
        end
        OP_NOT: if (depth < 1) f = F_UNDER;
                else opstack[depth-1] = (opstack[depth-1] == 0) ? 32'd1 : 32'd0;
        OP_OUT: begin
          if (depth < 1) f = F_UNDER;
          else begin depth--; r.out_valid = 1; r.out_value = opstack[depth]; end
        end
        OP_CAL: begin
          if (top_ptr + 1 >= FRAME_DEPTH) f = F_ADDR;
          else if (o < 0 || o >= CODE_DEPTH) f = F_TARGET;
          else begin
            frame_words[top_ptr] = base_ptr;
            frame_words[top_ptr+1] = nip;
            base_ptr = top_ptr;
            nip = 32'(o);
          end
        end
        OP_ENTER: begin
          t = longint'(top_ptr) + o;
          if (t < 0 || t >= FRAME_DEPTH) f = F_ADDR; else top_ptr = 32'(t);
        end
        OP_RETURN: begin
          if (base_ptr + 1 >= FRAME_DEPTH) f = F_ADDR;
          else begin
            rb = frame_words[base_ptr];
            ri = frame_words[base_ptr+1];
            if (rb >= FRAME_DEPTH) f = F_ADDR;
            else if (ri >= CODE_DEPTH) f = F_TARGET;
            else begin top_ptr = base_ptr; base_ptr = rb; nip = ri; end
          end
        end
        default: ;
      endcase
      if (f != F_OK) begin nip = ip; r.out_valid = 0; r.out_value = 0; end
      ip = nip;
      r.next_ip = nip[11:0];
      r.halted = (nip >= plen);
      r.fault = f;
      pending = {pending, r};
    endfunction

    function void check_result(exec_result_t got);
      exec_result_t exp;
      checked++;
      if (got.out_valid) outs_seen++;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", got);
        return;
      end
      exp = pending.pop_front();
      if (got !== exp) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("mismatch: expected ip %0d ov %0b val %h halt %0b fault %0d",
                   exp.next_ip, exp.out_valid, exp.out_value, exp.halted, exp.fault);
          $display("          got      ip %0d ov %0b val %h halt %0b fault %0d",
                   got.next_ip, got.out_valid, got.out_value, got.halted, got.fault);
        end
      end
    endfunction
  endclass

  logic clk, rst_n;
  logic in_valid, in_stall, out_valid, out_stall;
  logic [4:0] in_kind;
  logic signed [31:0] in_operand, in_in_value;
  logic [NIP_W-1:0] out_next_ip;
  logic out_out_valid, out_halted;
  logic signed [31:0] out_out_value;
  logic [2:0] out_fault;
  logic psel, penable, pwrite, pready;
  logic [PADDR_W-1:0] paddr;
  logic [31:0] pwdata, prdata;

  exec_scoreboard sb;
  int items_sent;

  stack_machine_execute_unit DUT (.*);

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  initial begin
    #50ms;
    $display("simulation failed");
    $finish;
  end

  // receiver: random stall per result
  initial begin
    int w;
    out_stall = 1;
    @(posedge rst_n);
    forever begin
      w = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 8);
      if (w > 0) begin
        out_stall <= 1;
        repeat (w) @(posedge clk);
      end
      out_stall <= 0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      sb.check_result({out_next_ip, out_out_valid, out_out_value, out_halted, out_fault});
    end
  end

  task automatic write_plen(int unsigned len);
    psel <= 1; penable <= 0; pwrite <= 1;
    paddr <= {REG_PROGRAM_LENGTH, 2'b00}; pwdata <= len;
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 0; penable <= 0; pwrite <= 0;
    sb.plen = len;
    // read back the register
    @(posedge clk);
    if (prdata !== len) begin
      sb.mismatches++;
      if (sb.mismatches <= 10)
        $display("mismatch: program length expected %0d, got %0d", len, prdata);
    end
  endtask

  task automatic idle_before_item();
    int w;
    w = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 8);
    if (w > 0) begin
      in_valid <= 0;
      repeat (w) @(posedge clk);
    end
  endtask

  task automatic send_instr(opcode_t k, logic signed [31:0] opnd, logic [31:0] inv = 0);
    idle_before_item();
    in_valid <= 1; in_kind <= k; in_operand <= opnd; in_in_value <= inv;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_instr(k, opnd, inv);
    items_sent++;
  endtask

  task automatic send_raw(logic [4:0] k, logic signed [31:0] opnd, logic [31:0] inv);
    idle_before_item();
    in_valid <= 1; in_kind <= k; in_operand <= opnd; in_in_value <= inv;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_instr(k, opnd, inv);
    items_sent++;
  endtask

  task automatic drain();
    int guard;
    guard = 0;
    in_valid <= 0;
    while (sb.pending.size() != 0 && guard < 200000) begin
      @(posedge clk);
      guard++;
    end
    repeat (60) @(posedge clk);
  endtask

  function automatic logic signed [31:0] rand_operand();
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return $urandom_range(0, 30);
      2: return 1001 + $urandom_range(0, 40);
      3: return -$urandom_range(0, 4);
      4: return $urandom_range(0, 60);
      default: return 32'sh7fffffff - $urandom_range(0, 1);
    endcase
  endfunction

  // mostly well formed: operands pushed before consumers, jumps stay in range
  task automatic random_phase(int n);
    opcode_t k;
    logic signed [31:0] o;
    for (int i = 0; i < n; i++) begin
      if (sb.ip >= sb.plen) begin
        send_instr(OP_BR, 0);
        continue;
      end
      if ($urandom_range(0, 9) == 0) begin
        send_raw(5'($urandom_range(0, 31)), $urandom, $urandom);
        continue;
      end
      if (sb.depth < 2 && $urandom_range(0, 3) != 0)
        k = ($urandom_range(0, 1) == 1) ? OP_LOADI : OP_IN;
      else
        k = opcode_t'($urandom_range(OP_LOAD, OP_RETURN));
      o = rand_operand();
      if (k inside {OP_BR, OP_BRF, OP_CAL} && $urandom_range(0, 4) != 0)
        o = $urandom_range(0, 60);
      if (k == OP_ENTER && $urandom_range(0, 3) != 0) o = $urandom_range(0, 6);
      send_instr(k, o, $urandom);
    end
  endtask

  initial begin
    int unsigned lens [4];
    sb = new();
    sb.clear_state();
    rst_n = 0; in_valid = 0; in_kind = 0; in_operand = 0; in_in_value = 0;
    psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // halted at reset with zero length
    send_instr(OP_LOADI, 5);
    drain();
    write_plen(4096);
    send_instr(OP_LOADI, 32'sh80000000);
    send_instr(OP_LOADI, -1);
    send_instr(OP_DIV, 0);
    send_instr(OP_OUT, 0);
    send_instr(OP_OUT, 0);
    send_instr(OP_IN, 0, 32'hffffffff);
    send_instr(OP_LOADI, 0);
    send_instr(OP_DIV, 0);
    send_instr(OP_STO, 1040);
    send_instr(OP_STO, 2024);
    send_instr(OP_LOAD, 1040);
    send_instr(OP_LOAD, -1);
    send_instr(OP_ADD, 0);
    send_instr(OP_NOT, 0);
    send_instr(OP_BRF, 4096);
    send_instr(OP_BR, -1);
    send_instr(OP_BR, 4095);
    send_instr(OP_BR, 10);
    send_instr(OP_CAL, 20);
    send_instr(OP_ENTER, 1023);
    send_instr(OP_ENTER, -1020);
    send_instr(OP_RETURN, 0);
    send_raw(5'd31, 0, 0);
    drain();
    // fill the stack to overflow
    for (int i = 0; i < EVAL_DEPTH + 1; i++) send_raw(OP_IN, 0, $urandom);
    for (int i = 0; i < EVAL_DEPTH + 1; i++) send_raw(OP_OUT, 0, 0);
    drain();

    lens = '{0, 1, 4096, 0};
    lens[3] = $urandom_range(20, 80);
    for (int p = 0; p < 4; p++) begin
      write_plen(p == 0 ? 4096 : lens[p]);
      random_phase(60);
      drain();
    end

    $display("ran %0d items, checked %0d results, %0d with an output value",
             items_sent, sb.checked, sb.outs_seen);
    if (sb.mismatches == 0 && sb.pending.size() == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end
endmodule
